FILE: src/sorted_threshold_histogram_assert.svh
// Assertion macros for the sorted-boundary histogram.
`ifndef SORTED_THRESHOLD_HISTOGRAM_ASSERT_SVH
`define SORTED_THRESHOLD_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define STH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define STH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define STH_ASSERT_IMP(label, ante, cons)
`define STH_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: src/sth_pkg.sv
// Shared types and constants for the sorted-boundary histogram.
package sth_pkg;

    localparam int MAX_SEP_DEF    = 128;
    localparam int COUNT_BITS_DEF = 48;
    localparam int VAL_W          = 64;
    localparam int BIN_W          = 8;
    localparam int CNT_W          = 48;
    localparam int CMD_W          = 2;
    localparam int STAT_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } sth_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2
    } sth_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_FETCH,
        ST_DECIDE,
        ST_SHR,
        ST_SHW,
        ST_EMIT
    } sth_state_t;

    // classified command as it sits in the queue
    typedef struct packed {
        sth_cmd_t         op;
        logic             search;
        logic [VAL_W-1:0] value;
        logic [BIN_W-1:0] sel;
    } sth_item_t;

endpackage

FILE: src/sth_if.sv
// Channel interfaces: command in, result out.
interface sth_req_if;
    import sth_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    logic [BIN_W-1:0] bin_select;
    modport source (output valid, cmd, value, bin_select, input ready);
    modport sink   (input valid, cmd, value, bin_select, output ready);
endinterface

interface sth_rsp_if;
    import sth_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BIN_W-1:0]  bin;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  upper_bound;
    logic              bound_is_max;
    modport source (output valid, status, bin, count, upper_bound, bound_is_max, input ready);
    modport sink   (input valid, status, bin, count, upper_bound, bound_is_max, output ready);
endinterface

FILE: src/sth_front.sv
// Front end: takes commands, classifies them and queues two deep.
module sth_front
    import sth_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sth_req_if.sink   req,
    output sth_item_t item,
    output logic      item_valid,
    input  logic      item_pop
);

    sth_item_t  q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    sth_item_t  cls;
    logic       push;

    always_comb
    begin
        cls.value = req.value;
        cls.sel   = req.bin_select;
        unique case (req.cmd)
            CMD_ADD:
            begin
                cls.op     = CMD_ADD;
                cls.search = 1'b1;
            end
            CMD_COUNT:
            begin
                cls.op     = CMD_COUNT;
                cls.search = 1'b1;
            end
            CMD_READ:
            begin
                cls.op     = CMD_READ;
                cls.search = 1'b0;
            end
            default:
            begin
                cls.op     = CMD_CLEAR;
                cls.search = 1'b0;
            end
        endcase
    end

    assign req.ready  = (fill_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign item_valid = (fill_reg != 2'd0);
    assign item       = q_reg[rp_reg];

    always_comb
    begin
        wp_next   = push ? ~wp_reg : wp_reg;
        rp_next   = item_pop ? ~rp_reg : rp_reg;
        fill_next = fill_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: src/sth_back.sv
// Back end: boundary table, bin counters and the command sequencer.
module sth_back
    import sth_pkg::*;
#(
    parameter int MAX_SEP    = MAX_SEP_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sth_item_t item,
    input  logic      item_valid,
    output logic      item_pop,
    sth_rsp_if.source rsp
);

    localparam int BW = $clog2(MAX_SEP + 1);
    localparam int TW = (MAX_SEP > 1) ? $clog2(MAX_SEP) : 1;
    localparam int NB = MAX_SEP + 1;

    logic [VAL_W-1:0]      tbl  [MAX_SEP];
    logic [COUNT_BITS-1:0] cmem [NB];
    logic [NB-1:0]         cvld_reg;

    logic [VAL_W-1:0]      tb_rd_reg;
    logic [COUNT_BITS-1:0] cm_rd_reg;
    logic                  cv_rd_reg;

    logic                  tb_we;
    logic [TW-1:0]         tb_wa, tb_ra;
    logic [VAL_W-1:0]      tb_wd;
    logic                  cm_we;
    logic [BW-1:0]         cm_wa, cm_ra;
    logic [COUNT_BITS-1:0] cm_wd;
    logic                  cv_we, cv_wd, cv_clr;

    sth_state_t            state_reg, state_next;
    sth_cmd_t              op_reg, op_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [BW-1:0]         n_reg, n_next;
    logic [BW-1:0]         lo_reg, lo_next;
    logic [BW-1:0]         hi_reg, hi_next;
    logic [BW-1:0]         mid_reg, mid_next;
    logic [BW-1:0]         i_reg, i_next;

    sth_status_t           rs_reg, rs_next;
    logic [BW-1:0]         rb_reg, rb_next;
    logic [COUNT_BITS-1:0] rc_reg, rc_next;
    logic [VAL_W-1:0]      ru_reg, ru_next;
    logic                  rm_reg, rm_next;

    logic                  ov_reg, ov_next;
    logic                  load;
    logic [STAT_W-1:0]     os_reg;
    logic [BIN_W-1:0]      ob_reg;
    logic [CNT_W-1:0]      oc_reg;
    logic [VAL_W-1:0]      ou_reg;
    logic                  om_reg;

    logic [BW:0]           mid_sum;
    logic [COUNT_BITS-1:0] cnt_val, cnt_inc;
    logic                  p_in;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign cnt_val = cv_rd_reg ? cm_rd_reg : '0;
    assign cnt_inc = (&cnt_val) ? cnt_val : cnt_val + 1'b1;
    assign p_in    = (lo_reg < n_reg);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        n_next     = n_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        i_next     = i_reg;
        rs_next    = rs_reg;
        rb_next    = rb_reg;
        rc_next    = rc_reg;
        ru_next    = ru_reg;
        rm_next    = rm_reg;
        item_pop   = 1'b0;
        load       = 1'b0;
        tb_we      = 1'b0;
        tb_wa      = lo_reg[TW-1:0];
        tb_wd      = val_reg;
        tb_ra      = lo_reg[TW-1:0];
        cm_we      = 1'b0;
        cm_wa      = lo_reg;
        cm_wd      = cnt_inc;
        cm_ra      = lo_reg;
        cv_we      = 1'b0;
        cv_wd      = 1'b0;
        cv_clr     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    op_next  = item.op;
                    val_next = item.value;
                    lo_next  = '0;
                    hi_next  = n_reg;
                    rs_next  = STAT_OK;
                    rb_next  = '0;
                    rc_next  = '0;
                    ru_next  = '0;
                    rm_next  = 1'b0;
                    if (item.op == CMD_CLEAR)
                    begin
                        cv_clr     = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (item.op == CMD_ADD && 32'(n_reg) >= MAX_SEP)
                    begin
                        rs_next    = STAT_FULL;
                        state_next = ST_EMIT;
                    end
                    else if (item.search)
                    begin
                        state_next = ST_SRCH;
                    end
                    else
                    begin
                        lo_next    = (16'(item.sel) > 16'(n_reg)) ? n_reg : BW'(item.sel);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[BW:1];
                    tb_ra      = mid_sum[TW:1];
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_CMP:
            begin
                if (val_reg <= tb_rd_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = ST_SRCH;
            end
            ST_FETCH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                rb_next = lo_reg;
                unique case (op_reg)
                    CMD_ADD:
                    begin
                        if (p_in && tb_rd_reg == val_reg)
                        begin
                            rs_next    = STAT_DUP;
                            rc_next    = cnt_val;
                            ru_next    = val_reg;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            i_next     = n_reg + 1'b1;
                            state_next = ST_SHR;
                        end
                    end
                    CMD_COUNT:
                    begin
                        cm_we      = 1'b1;
                        cv_we      = 1'b1;
                        cv_wd      = 1'b1;
                        rc_next    = cnt_inc;
                        ru_next    = p_in ? tb_rd_reg : '0;
                        rm_next    = !p_in;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        rc_next    = cnt_val;
                        ru_next    = p_in ? tb_rd_reg : '0;
                        rm_next    = !p_in;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_SHR:
            begin
                if (i_reg > lo_reg)
                begin
                    tb_ra      = TW'(i_reg - 1'b1);
                    cm_ra      = i_reg - 1'b1;
                    state_next = ST_SHW;
                end
                else
                begin
                    // slot is open: drop the new boundary in, its bin starts empty
                    tb_we      = 1'b1;
                    cv_we      = 1'b1;
                    cv_wd      = 1'b0;
                    n_next     = n_reg + 1'b1;
                    ru_next    = val_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_SHW:
            begin
                cm_we = 1'b1;
                cm_wa = i_reg;
                cm_wd = cm_rd_reg;
                cv_we = 1'b1;
                cv_wd = cv_rd_reg;
                if (i_reg <= n_reg)
                begin
                    tb_we = 1'b1;
                    tb_wa = TW'(i_reg);
                    tb_wd = tb_rd_reg;
                end
                i_next     = i_reg - 1'b1;
                state_next = ST_SHR;
            end
            ST_EMIT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ov_next = load ? 1'b1 : (rsp.ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            tbl[tb_wa] <= tb_wd;
        end
        tb_rd_reg <= tbl[tb_ra];
        if (cm_we)
        begin
            cmem[cm_wa] <= cm_wd;
        end
        cm_rd_reg <= cmem[cm_ra];
        cv_rd_reg <= cvld_reg[cm_ra];
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        i_reg   <= i_next;
        rs_reg  <= rs_next;
        rb_reg  <= rb_next;
        rc_reg  <= rc_next;
        ru_reg  <= ru_next;
        rm_reg  <= rm_next;
        if (load)
        begin
            os_reg <= rs_reg;
            ob_reg <= BIN_W'(rb_reg);
            oc_reg <= CNT_W'(rc_reg);
            ou_reg <= ru_reg;
            om_reg <= rm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            cvld_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
            if (cv_clr)
            begin
                cvld_reg <= '0;
            end
            else if (cv_we)
            begin
                cvld_reg[cm_wa] <= cv_wd;
            end
        end
    end

    assign rsp.valid        = ov_reg;
    assign rsp.status       = os_reg;
    assign rsp.bin          = ob_reg;
    assign rsp.count        = oc_reg;
    assign rsp.upper_bound  = ou_reg;
    assign rsp.bound_is_max = om_reg;

endmodule

FILE: src/sorted_threshold_histogram.sv
// Top level of the sorted-boundary histogram: front queue, back sequencer, checks.
//
//   channel | dir | transfer moves
//   --------+-----+-------------------------------------------------
//   req     | in  | cmd, value, bin_select
//   rsp     | out | status, bin, count, upper_bound, bound_is_max
//
// Count: a binary search over the n boundaries; it shares the one registered read port of
//   the boundary table, with an SRCH and a CMP state per step.
// Add: the search, then an SHR read and an SHW write per bin moved up (n+1-p of them)
//   through the single write port of each memory. Read skips the search; clear goes to EMIT.
// Reset clears the boundary count and the per-bin valid flags; no clearing pass.
// A two-deep queue lets req take up to two commands while the back end works or rsp is stalled.
`include "sorted_threshold_histogram_assert.svh"
module sorted_threshold_histogram
    import sth_pkg::*;
#(
    parameter int MAX_SEP    = MAX_SEP_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    sth_req_if.sink   req,
    sth_rsp_if.source rsp
);

    // classified command handed from front to back
    sth_item_t item;
    logic      item_valid;
    logic      item_pop;

    sth_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    sth_back #(
        .MAX_SEP    (MAX_SEP),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .rsp        (rsp)
    );

    // the open-ended last bin never reports an upper bound
    `STH_ASSERT_IMP(a_last_bin_ub, rsp.valid && rsp.bound_is_max, rsp.upper_bound == '0)
    // rejected adds never name the last bin
    `STH_ASSERT_IMP(a_reject_bin, rsp.valid && rsp.status != STAT_OK, !rsp.bound_is_max)
    // status stays within its defined codes
    `STH_ASSERT_IMP(a_status_code, rsp.valid, rsp.status <= STAT_FULL)
    // back end only pulls from a non-empty queue
    `STH_ASSERT_IMP(a_pop_valid, item_pop, item_valid)

endmodule

FILE: test/tb_sorted_threshold_histogram.sv
// Self-checking testbench for the sorted-boundary histogram.
module tb_sorted_threshold_histogram;
    import sth_pkg::*;

    localparam int NSEP = 128;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef struct {
        sth_status_t       status;
        logic [BIN_W-1:0]  bin;
        logic [CNT_W-1:0]  count;
        logic [VAL_W-1:0]  upper_bound;
        logic              bound_is_max;
    } hist_rsp_t;

    logic clk;
    logic rst_n;

    sth_req_if req ();
    sth_rsp_if rsp ();

    sorted_threshold_histogram u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow of the block's state
    logic [VAL_W-1:0] bounds [NSEP];
    int               n_bounds;
    logic [CNT_W-1:0] bin_cnt [NSEP+1];

    hist_rsp_t expected_rsps [$];
    int        errors;
    bit        stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: worst case is well under this
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic int find_bin(logic [VAL_W-1:0] v);
        for (int j = 0; j < n_bounds; j++)
        begin
            if (v <= bounds[j])
                return j;
        end
        return n_bounds;
    endfunction

    function automatic hist_rsp_t bin_view(int b);
        hist_rsp_t r;
        r.status       = STAT_OK;
        r.bin          = b[BIN_W-1:0];
        r.count        = bin_cnt[b];
        r.upper_bound  = (b >= n_bounds) ? '0 : bounds[b];
        r.bound_is_max = (b >= n_bounds);
        return r;
    endfunction

    // Predicts the response of one command and updates the shadow state
    function automatic hist_rsp_t predict_hist(sth_cmd_t op, logic [VAL_W-1:0] v,
                                               logic [BIN_W-1:0] sel);
        hist_rsp_t r;
        int        p;
        r = '{STAT_OK, '0, '0, '0, 1'b0};
        case (op)
            CMD_ADD:
            begin
                if (n_bounds >= NSEP)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    p = find_bin(v);
                    if (p < n_bounds && bounds[p] == v)
                    begin
                        r.status = STAT_DUP;
                        r.bin = p[BIN_W-1:0];
                        r.count = bin_cnt[p];
                        r.upper_bound = v;
                    end
                    else
                    begin
                        // counters move up with their boundaries
                        for (int j = n_bounds; j > p; j--)
                        begin
                            bounds[j]  = bounds[j-1];
                        end
                        for (int j = n_bounds + 1; j > p; j--)
                        begin
                            bin_cnt[j] = bin_cnt[j-1];
                        end
                        bounds[p]  = v;
                        bin_cnt[p] = '0;
                        n_bounds++;
                        r.bin = p[BIN_W-1:0];
                        r.upper_bound = v;
                    end
                end
            end
            CMD_COUNT:
            begin
                p = find_bin(v);
                if (bin_cnt[p] != CNT_SAT)
                    bin_cnt[p]++;
                r = bin_view(p);
            end
            CMD_READ:
            begin
                p = (int'(sel) > n_bounds) ? n_bounds : int'(sel);
                r = bin_view(p);
            end
            default:
            begin
                for (int j = 0; j <= NSEP; j++)
                    bin_cnt[j] = '0;
            end
        endcase
        return r;
    endfunction

    // Sends one command; expectation is queued at the accepting edge
    task automatic send_cmd(sth_cmd_t op, logic [VAL_W-1:0] v, logic [BIN_W-1:0] sel);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.cmd        <= op;
        req.value      <= v;
        req.bin_select <= sel;
        do
            @(posedge clk);
        while (!req.ready);
        expected_rsps.push_back(predict_hist(op, v, sel));
    endtask

    // Result checker with random back-pressure
    initial
    begin
        hist_rsp_t e;
        int        stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected transfer bin=%0d", $time, rsp.bin);
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (rsp.status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
                    errors++;
                end
                if (rsp.bin !== e.bin)
                begin
                    $display("%0t: bin exp %0d got %0d", $time, e.bin, rsp.bin);
                    errors++;
                end
                if (rsp.count !== e.count)
                begin
                    $display("%0t: count exp %0d got %0d", $time, e.count, rsp.count);
                    errors++;
                end
                if (rsp.upper_bound !== e.upper_bound)
                begin
                    $display("%0t: upper_bound exp %0h got %0h", $time, e.upper_bound,
                             rsp.upper_bound);
                    errors++;
                end
                if (rsp.bound_is_max !== e.bound_is_max)
                begin
                    $display("%0t: bound_is_max exp %0b got %0b", $time, e.bound_is_max,
                             rsp.bound_is_max);
                    errors++;
                end
            end
        end
    end

    function automatic logic [VAL_W-1:0] rand_val();
        return {$urandom(), $urandom()};
    endfunction

    // Values near existing boundaries hit the inclusive edges
    function automatic logic [VAL_W-1:0] near_val();
        logic [VAL_W-1:0] b;
        if (n_bounds == 0)
            return rand_val();
        b = bounds[$urandom_range(0, n_bounds - 1)];
        case ($urandom_range(0, 2))
            0: return b - 1;
            1: return b;
            default: return b + 1;
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(CMD_READ, '0, 8'd0);             // empty table: last bin
        send_cmd(CMD_COUNT, '0, '0);
        send_cmd(CMD_COUNT, '1, '0);
        send_cmd(CMD_ADD, 64'd1000, '0);
        send_cmd(CMD_ADD, 64'd10, '0);
        send_cmd(CMD_ADD, '1, '0);                 // top value as boundary
        send_cmd(CMD_ADD, '0, '0);                 // zero as boundary
        send_cmd(CMD_ADD, 64'd10, '0);             // duplicate
        send_cmd(CMD_COUNT, 64'd10, '0);           // on a boundary
        send_cmd(CMD_COUNT, 64'd11, '0);
        send_cmd(CMD_COUNT, '0, '0);
        send_cmd(CMD_COUNT, '1, '0);
        send_cmd(CMD_ADD, 64'd500, '0);            // insert moves counters up
        send_cmd(CMD_READ, '0, 8'd3);
        send_cmd(CMD_READ, '0, 8'd5);              // last bin exactly
        send_cmd(CMD_READ, '0, 8'hFF);             // beyond range
        send_cmd(CMD_CLEAR, '1, 8'hFF);
        send_cmd(CMD_READ, '0, 8'd1);
    endtask

    task automatic test_fill_table();
        // fill to the limit, then full and full-duplicate adds
        while (n_bounds < NSEP)
            send_cmd(CMD_ADD, ($urandom_range(0, 1) ? rand_val() : near_val()), '0);
        send_cmd(CMD_ADD, rand_val(), '0);
        send_cmd(CMD_ADD, bounds[5], '0);
        send_cmd(CMD_READ, '0, 8'd128);
        send_cmd(CMD_READ, '0, 8'd129);
    endtask

    task automatic test_random(int n_cmds);
        int k;
        for (int i = 0; i < n_cmds; i++)
        begin
            k = $urandom_range(0, 19);
            if (k < 10)
                send_cmd(CMD_COUNT, ($urandom_range(0, 1) ? near_val() : rand_val()),
                         8'($urandom()));
            else if (k < 14)
                send_cmd(CMD_ADD, ($urandom_range(0, 1) ? near_val() : rand_val()),
                         8'($urandom()));
            else if (k < 19)
                send_cmd(CMD_READ, rand_val(), ($urandom_range(0, 3) == 0) ?
                         8'($urandom()) : 8'($urandom_range(0, 129)));
            else
                send_cmd(CMD_CLEAR, rand_val(), 8'($urandom()));
        end
    endtask

    initial
    begin
        errors   = 0;
        n_bounds = 0;
        for (int j = 0; j <= NSEP; j++)
            bin_cnt[j] = '0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.cmd        = CMD_ADD;
        req.value      = '0;
        req.bin_select = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150);
        test_fill_table();
        test_random(150);
        req.valid <= 1'b0;

        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/sth_pkg.sv
src/sth_if.sv
src/sth_front.sv
src/sth_back.sv
src/sorted_threshold_histogram.sv
test/tb_sorted_threshold_histogram.sv
